/* rtl/kkr_pkg.sv */
// ----------------------------------------------------------------------------
// kkr_pkg
// Shared widths and defaults for the Karmarkar-Karp residue block.
// ----------------------------------------------------------------------------
package kkr_pkg;

  localparam int BIN_W          = 48;
  localparam int GROUP_W        = 7;
  localparam int DEF_MAX_BINS   = 128;
  localparam int DEF_VALUE_BITS = 40;

  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

endpackage

/* rtl/karmarkar_karp_residue.sv */
// ----------------------------------------------------------------------------
// karmarkar_karp_residue
// Grouped bin accumulation followed by largest-differencing to one residue.
// ----------------------------------------------------------------------------
// Usage:
//   An item (value, group, last) is taken on a rising edge with start high
//   and busy low. The value is added, saturating at 2^48-1, into bin[group];
//   groups at or above MAX_BINS are dropped but still count for last.
//   An item without last is added into its bin, then busy falls again.
//   An item with last runs differencing: each pass scans all bins through
//   the single memory read port, then subtracts the second largest bin from
//   the largest and zeroes it. Passes repeat until at most one bin is
//   nonzero; there are at most max(n,1) passes for n nonzero bins, the last
//   one without the zeroing write.
//   The residue appears on residue with done high for exactly one cycle;
//   the receiver cannot stall it. Differencing leaves every bin at zero.
//   After rst the bins are cleared one per cycle, with busy high, before
//   the first item is taken.
// ----------------------------------------------------------------------------
module karmarkar_karp_residue #(
  parameter int MAX_BINS   = kkr_pkg::DEF_MAX_BINS,
  parameter int VALUE_BITS = kkr_pkg::DEF_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [VALUE_BITS-1:0]       value,
  input  logic [kkr_pkg::GROUP_W-1:0] group,
  input  logic                        last,
  output logic                        done,
  output logic [kkr_pkg::BIN_W-1:0]   residue
);

  import kkr_pkg::*;

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int SUM_W = ((VALUE_BITS > BIN_W) ? VALUE_BITS : BIN_W) + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_BINS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_ZERO
  } state_t;

  state_t state;

  logic [BIN_W-1:0]      bins_mem [MAX_BINS];
  logic [BIN_W-1:0]      rdata;
  logic [IDX_W-1:0]      rd_addr;
  logic                  we;
  logic [IDX_W-1:0]      wa;
  logic [BIN_W-1:0]      wd;

  logic [IDX_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] val_r;
  logic [IDX_W-1:0]      gidx_r;
  logic                  in_range_r;
  logic                  last_r;
  logic                  rv;
  logic [IDX_W-1:0]      ridx;
  logic [BIN_W-1:0]      t1v, t2v;
  logic [IDX_W-1:0]      t1i, t2i;

  logic [IDX_W-1:0]      gidx_in;
  logic                  in_range_in;
  logic [SUM_W-1:0]      sum;
  logic [BIN_W-1:0]      sat_sum;
  logic [BIN_W-1:0]      diff;

  assign busy        = (state != S_IDLE);
  assign gidx_in     = IDX_W'(group);
  assign in_range_in = (32'(group) < 32'(MAX_BINS));
  assign sum         = SUM_W'(rdata) + SUM_W'(val_r);
  assign sat_sum     = (sum > SUM_W'(BIN_MAX)) ? BIN_MAX : sum[BIN_W-1:0];
  assign diff        = t1v - t2v;

  always_comb begin
    rd_addr = cnt;
    we      = 1'b0;
    wa      = cnt;
    wd      = '0;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        rd_addr = gidx_in;
      end
      S_ADD: begin
        we = in_range_r;
        wa = gidx_r;
        wd = sat_sum;
      end
      S_DECIDE: begin
        we = 1'b1;
        wa = t1i;
        wd = (t2v == '0) ? '0 : diff;
      end
      S_ZERO: begin
        we = 1'b1;
        wa = t2i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      bins_mem[wa] <= wd;
    end
    rdata <= bins_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      rv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (rv) begin
        if (rdata > t1v) begin
          t2v <= t1v;
          t2i <= t1i;
          t1v <= rdata;
          t1i <= ridx;
        end else if (rdata > t2v) begin
          t2v <= rdata;
          t2i <= ridx;
        end
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == IDX_LAST) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            val_r      <= value;
            gidx_r     <= gidx_in;
            in_range_r <= in_range_in;
            last_r     <= last;
            state      <= S_ADD;
          end
        end
        S_ADD: begin
          if (last_r) begin
            cnt   <= '0;
            t1v   <= '0;
            t2v   <= '0;
            t1i   <= '0;
            t2i   <= '0;
            state <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          rv   <= 1'b1;
          ridx <= cnt;
          cnt  <= cnt + 1'b1;
          if (cnt == IDX_LAST) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          rv    <= 1'b0;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (t2v == '0) begin
            residue <= t1v;
            done    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            state <= S_ZERO;
          end
        end
        S_ZERO: begin
          cnt   <= '0;
          t1v   <= '0;
          t2v   <= '0;
          t1i   <= '0;
          t2i   <= '0;
          state <= S_SCAN;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_done_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(state) == S_DECIDE)
    else $error("done raised outside decide");

  a_top_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> (t2v <= t1v))
    else $error("second largest exceeds largest");

  a_top_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && t2v != '0) |-> (t1i != t2i))
    else $error("largest pair shares one bin");
`endif

endmodule

/* tb/karmarkar_karp_residue_check.sv */
// ----------------------------------------------------------------------------
// karmarkar_karp_residue_check
// Watches the item and result ports of the residue block, keeps its own copy
// of the per-group bins, predicts the largest-differencing residue of every
// set that closes with last, and compares it with each done strobe in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module karmarkar_karp_residue_check #(
  parameter int MAX_BINS = kkr_pkg::DEF_MAX_BINS,
  parameter int VALUE_W  = kkr_pkg::DEF_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [VALUE_W-1:0]          value,
  input  logic [kkr_pkg::GROUP_W-1:0] group,
  input  logic                        last,
  input  logic                        done,
  input  logic [kkr_pkg::BIN_W-1:0]   residue,
  output int                          fail_count,
  output int                          expected_left
);

  localparam int BIN_W = kkr_pkg::BIN_W;

  logic [BIN_W-1:0] bin_sum [MAX_BINS];
  logic [BIN_W-1:0] residues_due [$];
  int               mismatches = 0;

  // Repeatedly replace the two largest bins by their difference.
  function automatic logic [BIN_W-1:0] reduce_bins();
    int               top_i;
    int               next_i;
    logic             settled;
    logic [BIN_W-1:0] left;
    settled = 1'b0;
    left    = '0;
    while (!settled) begin
      top_i = 0;
      for (int i = 1; i < MAX_BINS; i++)
        if (bin_sum[i] > bin_sum[top_i]) top_i = i;
      next_i = -1;
      for (int i = 0; i < MAX_BINS; i++)
        if (i != top_i && (next_i < 0 || bin_sum[i] > bin_sum[next_i])) next_i = i;
      if (next_i < 0 || bin_sum[next_i] == '0) begin
        left    = bin_sum[top_i];
        settled = 1'b1;
      end else begin
        bin_sum[top_i]  = bin_sum[top_i] - bin_sum[next_i];
        bin_sum[next_i] = '0;
      end
    end
    return left;
  endfunction

  always @(posedge clk) begin : track
    logic [BIN_W:0]   sum;
    logic [BIN_W-1:0] want;
    if (rst) begin
      for (int i = 0; i < MAX_BINS; i++) bin_sum[i] = '0;
      residues_due.delete();
    end else begin
      if (done) begin
        if (residues_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: residue %0h with no set pending", $time, residue);
          mismatches++;
        end else begin
          want = residues_due.pop_front();
          if (residue !== want) begin
            if (mismatches < 10)
              $display("%0t: residue expected %0h, got %0h", $time, want, residue);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        if (group < MAX_BINS) begin
          sum = {1'b0, bin_sum[group]} + value;
          bin_sum[group] = sum[BIN_W] ? kkr_pkg::BIN_MAX : sum[BIN_W-1:0];
        end
        if (last) begin
          residues_due.insert(residues_due.size(), reduce_bins());
          for (int i = 0; i < MAX_BINS; i++) bin_sum[i] = '0;
        end
      end
    end
    fail_count    <= mismatches;
    expected_left <= residues_due.size();
  end

endmodule

/* tb/karmarkar_karp_residue_tb.sv */
// ----------------------------------------------------------------------------
// karmarkar_karp_residue_tb
// Drives sets of grouped numbers into the residue block: a directed opening,
// then random plain, prepartitioned, wide, all-group, saturating and noise sets sent in
// bursts with random gaps. The checker beside the block predicts residues.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module karmarkar_karp_residue_tb;

  localparam int VALUE_W        = kkr_pkg::DEF_VALUE_BITS;
  localparam int GROUP_W        = kkr_pkg::GROUP_W;
  localparam int BIN_W          = kkr_pkg::BIN_W;
  localparam int MAX_BINS       = kkr_pkg::DEF_MAX_BINS;
  localparam int ITEM_TARGET    = 1950;
  localparam int DRAIN_CYCLES   = 4 * (MAX_BINS + 3);
  localparam int WATCHDOG_LIMIT = 200000;

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic [GROUP_W-1:0] group = '0;
  logic               last  = 1'b0;
  logic               busy;
  logic               done;
  logic [BIN_W-1:0]   residue;

  int fail_count;
  int expected_left;
  int idle_cycles = 0;
  int items_sent  = 0;
  int burst_left  = 1;
  bit no_idle     = 1'b0;

  karmarkar_karp_residue dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .value   (value),
    .group   (group),
    .last    (last),
    .done    (done),
    .residue (residue)
  );

  karmarkar_karp_residue_check checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .group         (group),
    .last          (last),
    .done          (done),
    .residue       (residue),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [63:0] r;
    int          k;
    r = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    case (k)
      0:       return '0;
      1:       return '1;
      2:       return VALUE_W'(r[7:0]);
      3:       return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      default: return r[VALUE_W-1:0];
    endcase
  endfunction

  task automatic push_item(input logic [VALUE_W-1:0] v, input logic [GROUP_W-1:0] g,
                           input logic l);
    int gap;
    start <= 1'b1;
    value <= v;
    group <= g;
    last  <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off until every residue owed has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  task automatic send_set(input int n, input int pool_base, input int pool_size);
    for (int k = 0; k < n; k++)
      push_item(pick_value(), GROUP_W'(pool_base + $urandom_range(0, pool_size - 1)),
                k == n - 1);
  endtask

  initial begin
    int  k;
    int  g;
    bit  sat_done;
    bit  full_done;
    sat_done  = 1'b0;
    full_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty set, single max value, equal pair
    push_item('0, 7'd0, 1'b1);
    push_item('1, 7'd127, 1'b1);
    push_item(40'd5, 7'd3, 1'b0);
    push_item(40'd5, 7'd9, 1'b1);
    // shared group: bins 10 and 4
    push_item(40'd7, 7'd2, 1'b0);
    push_item(40'd3, 7'd2, 1'b0);
    push_item(40'd4, 7'd5, 1'b1);
    // classic differencing example
    push_item(40'd8, 7'd10, 1'b0);
    push_item(40'd7, 7'd20, 1'b0);
    push_item(40'd6, 7'd30, 1'b0);
    push_item(40'd5, 7'd40, 1'b0);
    push_item(40'd4, 7'd50, 1'b1);
    // wide and alternating bit patterns
    push_item('1, 7'd0, 1'b0);
    push_item(40'hAAAAAAAAAA, 7'd127, 1'b0);
    push_item(40'h5555555555, 7'd85, 1'b0);
    push_item(40'd1, 7'd42, 1'b1);
    settle();

    while (items_sent < ITEM_TARGET) begin
      no_idle = (items_sent >= 1200 && items_sent < 1500);
      if (!full_done && items_sent >= 400) begin
        for (int i = 0; i < MAX_BINS; i++)
          push_item(pick_value(), GROUP_W'(i), i == MAX_BINS - 1);
        full_done = 1'b1;
      end else if (!sat_done && items_sent >= 900) begin
        settle();
        g = $urandom_range(0, MAX_BINS - 1);
        repeat (270) push_item('1, GROUP_W'(g), 1'b0);
        send_set(3, g + 1, 100);
        sat_done = 1'b1;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          send_set($urandom_range(1, 12), 0, MAX_BINS);
        end else if (k < 80) begin
          send_set($urandom_range(2, 24), $urandom_range(0, MAX_BINS - 1),
                   $urandom_range(1, 6));
        end else if (k < 88) begin
          send_set($urandom_range(13, 64), 0, MAX_BINS);
        end else if (k < 96) begin
          repeat ($urandom_range(1, 6))
            push_item(pick_value(), GROUP_W'($urandom_range(0, MAX_BINS - 1)),
                      $urandom_range(0, 9) == 0);
        end else begin
          settle();
          send_set($urandom_range(1, 8), 0, MAX_BINS);
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
